// ----- hw/rtl/plist_pkg.sv -----
// plist_pkg: shared types, codes and sizes for the positional list engine
// used by plist_cell and positional_list_engine; depends on nothing else
package plist_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 5;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned VAL_W = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_FRONT  = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic [4:0]              entry_index;
    logic [1:0]              status;
    logic                    last_result;
  } rsp_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_INS  = 2'd1,
    C_DEL  = 2'd2,
    C_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                kind;
    logic [IDX_W-1:0]        slot;
    logic signed [VAL_W-1:0] item;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/plist_cell.sv -----
// plist_cell: one list slot, shifts with its neighbours on insert, delete, dump
// depends on plist_pkg
module plist_cell
  import plist_pkg::*;
(
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [VAL_W-1:0] left,
  input  logic signed [VAL_W-1:0] right,
  input  logic signed [VAL_W-1:0] head,
  output logic signed [VAL_W-1:0] value
);

  logic signed [VAL_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.kind)
      C_INS: begin
        if (idx > cmd.slot) begin
          value_next = left;
        end else if (idx == cmd.slot) begin
          value_next = cmd.item;
        end
      end
      C_DEL: begin
        if (idx >= cmd.slot) begin
          value_next = right;
        end
      end
      C_ROT: begin
        // rotate the used prefix, head wraps to the last used slot
        if (idx == cmd.slot) begin
          value_next = head;
        end else if (idx < cmd.slot) begin
          value_next = right;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- hw/rtl/positional_list_engine.sv -----
// Ordered list of up to DEPTH signed 32-bit values held in a row of shifting
// cells. Insert, delete, append and front requests leave busy low, and their
// single result appears in the cycle after the request. A dump of n entries
// gives n results on consecutive cycles, the first in the cycle after the
// request, and holds busy high until the last result appears while the cell
// row rotates once per entry; the row is back in order when the last
// result leaves. Results carry no back-pressure: each is valid for the one
// cycle that strobe is high. Bad positions and a full list are refused with
// an error status and leave the list untouched.
// depends on plist_pkg and plist_cell
module positional_list_engine
  import plist_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic strobe,
  output rsp_t result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [IDX_W-1:0]        dump_idx, dump_idx_next;
  logic                    strobe_next;
  rsp_t                    result_next;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cells [DEPTH];

  logic             accept;
  logic             full;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [IDX_W-1:0] emit_idx;
  logic [CNT_W-1:0] emit_pos;
  logic             emit_last;

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(DEPTH));
  assign pos_ext  = CMP_W'(request.position);
  assign cnt_ext  = CMP_W'(count);
  assign emit_idx = (state == S_DUMP) ? dump_idx : '0;
  assign emit_pos = CNT_W'(emit_idx) + CNT_W'(1);
  assign emit_last = (emit_pos == count);

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    strobe_next   = 1'b0;
    result_next   = '0;
    result_next.last_result = 1'b1;
    cmd.kind = C_HOLD;
    cmd.slot = '0;
    cmd.item = request.item_value;

    if (state == S_DUMP || (accept && request.operation == OP_DUMP && count != '0)) begin
      // read the head cell and rotate the used prefix by one
      cmd.kind = C_ROT;
      cmd.slot = IDX_W'(count - CNT_W'(1));
      strobe_next = 1'b1;
      result_next.entry_value = cells[0];
      result_next.entry_index = 5'(emit_pos);
      result_next.status      = ST_OK;
      result_next.last_result = emit_last;
      if (emit_last) begin
        state_next    = S_IDLE;
        dump_idx_next = '0;
      end else begin
        state_next    = S_DUMP;
        dump_idx_next = emit_idx + IDX_W'(1);
      end
    end else if (accept) begin
      strobe_next = 1'b1;
      case (request.operation)
        OP_INSERT: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
            result_next.status = ST_BADPOS;
          end else begin
            cmd.kind   = C_INS;
            cmd.slot   = IDX_W'(pos_ext - CMP_W'(1));
            count_next = count + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (pos_ext == '0 || pos_ext > cnt_ext) begin
            result_next.status = ST_BADPOS;
          end else begin
            cmd.kind   = C_DEL;
            cmd.slot   = IDX_W'(pos_ext - CMP_W'(1));
            count_next = count - CNT_W'(1);
          end
        end
        OP_APPEND: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            cmd.kind   = C_INS;
            cmd.slot   = IDX_W'(count);
            count_next = count + CNT_W'(1);
          end
        end
        OP_FRONT: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            cmd.kind   = C_INS;
            cmd.slot   = '0;
            count_next = count + CNT_W'(1);
          end
        end
        OP_DUMP: begin
          // only reached with an empty list
          result_next.status = ST_EMPTY;
        end
        default: result_next.status = ST_BADPOS;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = request.item_value;
    end else begin : g_mid_l
      assign left_val = cells[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cells[g];
    end else begin : g_mid_r
      assign right_val = cells[g+1];
    end

    plist_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (IDX_W'(g)),
      .left  (left_val),
      .right (right_val),
      .head  (cells[0]),
      .value (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dump_idx <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for positional_list_engine, driving list requests
// through the start/busy handshake and checking every strobed result in order
// depends on plist_pkg and the positional_list_engine rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plist_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic strobe;
  rsp_t result;

  positional_list_engine dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // shadow copy of the list, head first
  logic signed [VAL_W-1:0] list_shadow[$];
  rsp_t pending_results[$];
  int idle_pct;
  bit fail_seen;
  bit grow_mode;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t make_req(logic [2:0] op, logic [POS_W-1:0] pos,
                                    logic signed [VAL_W-1:0] val);
    req_t r;
    r.operation  = op;
    r.position   = pos;
    r.item_value = val;
    return r;
  endfunction

  function automatic rsp_t make_rsp(logic signed [VAL_W-1:0] val, logic [4:0] idx,
                                    logic [1:0] st, logic last);
    rsp_t r;
    r.entry_value = val;
    r.entry_index = idx;
    r.status      = st;
    r.last_result = last;
    return r;
  endfunction

  // extremes turn up often, the rest is uniform
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  // updates the shadow list and queues the results one request causes
  function automatic void predict_list_request(req_t r);
    int n;
    int p;
    logic [1:0] st;
    n  = list_shadow.size();
    p  = r.position;
    st = ST_OK;
    case (r.operation)
      OP_INSERT: begin
        if (n >= DEPTH) st = ST_FULL;
        else if (p == 0 || p > n + 1) st = ST_BADPOS;
        else list_shadow.insert(p - 1, r.item_value);
      end
      OP_DELETE: begin
        if (p == 0 || p > n) st = ST_BADPOS;
        else list_shadow.delete(p - 1);
      end
      OP_APPEND: begin
        if (n >= DEPTH) st = ST_FULL;
        else list_shadow.push_back(r.item_value);
      end
      OP_FRONT: begin
        if (n >= DEPTH) st = ST_FULL;
        else list_shadow.push_front(r.item_value);
      end
      OP_DUMP: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++)
            pending_results.push_back(make_rsp(list_shadow[i], 5'(i + 1), ST_OK,
                                               i == n - 1));
          return;
        end
      end
      default: st = ST_BADPOS;
    endcase
    pending_results.push_back(make_rsp('0, '0, st, 1'b1));
  endfunction

  task automatic send_request(input req_t r);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    predict_list_request(r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      request <= make_req(3'($urandom_range(7)), POS_W'($urandom_range(31)),
                          $signed($urandom));
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic test_empty_list();
    send_request(make_req(OP_DUMP, 5'd0, '0));
    send_request(make_req(OP_DELETE, 5'd1, '0));
    send_request(make_req(OP_DELETE, 5'd0, '0));
    send_request(make_req(OP_INSERT, 5'd0, 32'sd5));
    send_request(make_req(OP_INSERT, 5'd2, 32'sd6));
  endtask

  task automatic test_insert_order();
    send_request(make_req(OP_INSERT, 5'd1, 32'sh7fff_ffff));
    send_request(make_req(OP_APPEND, 5'd31, 32'sh8000_0000));
    send_request(make_req(OP_FRONT, 5'd0, -32'sd1));
    // position count+1 lands at the tail
    send_request(make_req(OP_INSERT, 5'd4, 32'sd0));
    send_request(make_req(OP_INSERT, 5'd2, 32'sh5555_5555));
    send_request(make_req(OP_INSERT, 5'd31, 32'shaaaa_aaaa));
    send_request(make_req(OP_DUMP, 5'd16, '0));
  endtask

  task automatic test_delete_positions();
    send_request(make_req(OP_DELETE, 5'd5, '0));
    send_request(make_req(OP_DELETE, 5'd1, '0));
    send_request(make_req(OP_DELETE, 5'd17, '0));
    send_request(make_req(OP_DUMP, 5'd0, '0));
  endtask

  task automatic test_reserved_codes();
    send_request(make_req(3'd5, 5'd1, 32'sd1));
    send_request(make_req(3'd6, 5'd2, 32'sd2));
    send_request(make_req(3'd7, 5'd31, -32'sd1));
    send_request(make_req(OP_DUMP, 5'd1, '0));
  endtask

  // list grows towards full, then drains towards empty, and so on
  task automatic test_random_traffic(input int n_items, input int idle);
    int n;
    int roll;
    logic [2:0] op;
    logic [POS_W-1:0] pos;
    idle_pct = idle;
    repeat (n_items) begin
      n = list_shadow.size();
      if (n == DEPTH && $urandom_range(3) == 0) grow_mode = 1'b0;
      if (n == 0 && $urandom_range(2) == 0) grow_mode = 1'b1;
      roll = $urandom_range(99);
      if (grow_mode) begin
        if (roll < 30) op = OP_INSERT;
        else if (roll < 50) op = OP_APPEND;
        else if (roll < 65) op = OP_FRONT;
        else if (roll < 78) op = OP_DELETE;
        else if (roll < 88) op = OP_DUMP;
        else op = 3'($urandom_range(7));
      end else begin
        if (roll < 55) op = OP_DELETE;
        else if (roll < 65) op = OP_INSERT;
        else if (roll < 70) op = OP_APPEND;
        else if (roll < 75) op = OP_FRONT;
        else if (roll < 88) op = OP_DUMP;
        else op = 3'($urandom_range(7));
      end
      pos = POS_W'($urandom_range(31));
      if ($urandom_range(99) < 85) begin
        if (op == OP_INSERT) pos = POS_W'($urandom_range(n + 1, 1));
        else if (op == OP_DELETE && n > 0) pos = POS_W'($urandom_range(n, 1));
      end
      send_request(make_req(op, pos, rand_value()));
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d index=%0d status=%0d last=%0b",
                 $time, result.entry_value, result.entry_index, result.status,
                 result.last_result);
        fail_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (result.entry_value !== want.entry_value) begin
          $display("%0t: entry_value expected %0d got %0d", $time,
                   want.entry_value, result.entry_value);
          fail_seen = 1'b1;
        end
        if (result.entry_index !== want.entry_index) begin
          $display("%0t: entry_index expected %0d got %0d", $time,
                   want.entry_index, result.entry_index);
          fail_seen = 1'b1;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   result.status);
          fail_seen = 1'b1;
        end
        if (result.last_result !== want.last_result) begin
          $display("%0t: last_result expected %0b got %0b", $time,
                   want.last_result, result.last_result);
          fail_seen = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    fail_seen   = 1'b0;
    grow_mode   = 1'b1;
    idle_pct    = 0;
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_order();
    test_delete_positions();
    test_reserved_codes();
    test_random_traffic(110, 0);
    test_random_traffic(110, 78);
    test_random_traffic(100, 11);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // anything strobed after this point is a stray result
    repeat (DEPTH + 4) @(posedge clk);
    if (!fail_seen) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/plist_pkg.sv
hw/rtl/plist_cell.sv
hw/rtl/positional_list_engine.sv
bench/tb.sv
